@@ rtl/core/psq_pkg.sv @@
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types and constants of the priority sorted wait queue.
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int unsigned CMD_W          = 2;
  localparam int unsigned MUTEX_W        = 2;
  localparam int unsigned TASK_W         = 4;
  localparam int unsigned PRIO_W         = 8;
  localparam int unsigned SLOT_W         = 5;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned QIDX_W         = 4;
  localparam int unsigned DEF_NUM_TASKS  = 16;
  localparam int unsigned DEF_NUM_QUEUES = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_CHANGE,
    CMD_REMOVE
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_MISMATCH
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [QIDX_W-1:0] queue;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

@@ rtl/core/psq_front.sv @@
// ----------------------------------------------------------------------------
// psq_front
// Accepts transactions and reduces the queue and task indexes into range.
// ----------------------------------------------------------------------------
module psq_front #(
  parameter int unsigned NUM_TASKS  = psq_pkg::DEF_NUM_TASKS,
  parameter int unsigned NUM_QUEUES = psq_pkg::DEF_NUM_QUEUES
) (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [psq_pkg::CMD_W-1:0]     command_i,
  input  logic [psq_pkg::MUTEX_W-1:0]   mutex_index_i,
  input  logic [psq_pkg::TASK_W-1:0]    task_id_i,
  input  logic [psq_pkg::PRIO_W-1:0]    priority_req_i,
  input  logic [psq_pkg::SLOT_W-1:0]    slot_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output psq_pkg::cmd_t                 cmd_o
);
  import psq_pkg::*;

  always_comb begin
    logic [QIDX_W-1:0] q;
    logic [TASK_W-1:0] t;
    q = {{(QIDX_W-MUTEX_W){1'b0}}, mutex_index_i};
    t = task_id_i;
    // narrow values, a few conditional subtractions
    for (int i = 0; i < 4; i++) begin
      if (int'(q) >= int'(NUM_QUEUES)) begin
        q = q - QIDX_W'(NUM_QUEUES);
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (int'(t) >= int'(NUM_TASKS)) begin
        t = t - TASK_W'(NUM_TASKS);
      end
    end
    cmd_o.cmd     = cmd_e'(command_i);
    cmd_o.queue   = q;
    cmd_o.task_id = t;
    cmd_o.prio    = priority_req_i;
    cmd_o.slot    = slot_i;
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

@@ rtl/core/psq_fifo.sv @@
// ----------------------------------------------------------------------------
// psq_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module psq_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  psq_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output psq_pkg::cmd_t rd_data_o
);
  import psq_pkg::*;

  cmd_t       buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = buf_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/core/psq_back.sv @@
// ----------------------------------------------------------------------------
// psq_back
// Executes commands on one queue row with a row of compare-and-swap cells.
// ----------------------------------------------------------------------------
module psq_back #(
  parameter int unsigned NUM_TASKS  = psq_pkg::DEF_NUM_TASKS,
  parameter int unsigned NUM_QUEUES = psq_pkg::DEF_NUM_QUEUES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  psq_pkg::cmd_t                 cmd_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [psq_pkg::STATUS_W-1:0]  status_o,
  output logic [psq_pkg::TASK_W-1:0]    out_task_o,
  output logic [psq_pkg::PRIO_W-1:0]    out_priority_o
);
  import psq_pkg::*;

  localparam int unsigned RING = NUM_TASKS + 1;
  localparam int unsigned SW   = $clog2(RING);
  localparam int unsigned QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned TIW  = $clog2(NUM_TASKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_SORT,
    S_WRITE,
    S_RESP
  } state_e;

  typedef logic [RING-1:0][TASK_W-1:0] row_t;

  function automatic logic [TIW-1:0] tidx(input logic [TASK_W-1:0] t);
    logic [TIW+TASK_W-1:0] e;
    e = {{TIW{1'b0}}, t};
    return e[TIW-1:0];
  endfunction

  state_e                        state_q;
  cmd_t                          cmd_q;
  logic [SW-1:0]                 head_q [NUM_QUEUES];
  logic [SW-1:0]                 tail_q [NUM_QUEUES];
  logic [SW-1:0]                 hn_q, tn_q, n_q, cnt_q;
  logic [PRIO_W-1:0]             prio_tab_q [NUM_TASKS];
  row_t                          mem_q [NUM_QUEUES];
  row_t                          rd_row_q;
  row_t                          work_q;
  logic [RING-1:0][PRIO_W-1:0]   wprio_q;
  status_e                       st_q, res_st_q;
  logic [TASK_W-1:0]             ot_q, res_task_q;
  logic [PRIO_W-1:0]             op_q, res_prio_q;
  logic                          res_valid_q;

  logic [QW-1:0]                 qi;
  logic [SW-1:0]                 h, t, n, tp1, hp1, tm1, off, sidx;
  logic                          full, slot_ok, live, match;
  row_t                          rot, sh, pu, po, wr_row;
  logic [TASK_W-1:0]             rem;

  always_comb begin
    int j;
    logic [SW+SLOT_W-1:0] se;
    qi = cmd_q.queue[QW-1:0];
    h  = head_q[qi];
    t  = tail_q[qi];
    j = int'(t) - int'(h);
    if (j < 0) j = j + int'(RING);
    n = SW'(j);
    j = int'(t) + 1;
    if (j == int'(RING)) j = 0;
    tp1 = SW'(j);
    j = int'(h) + 1;
    if (j == int'(RING)) j = 0;
    hp1 = SW'(j);
    j = int'(t) - 1;
    if (j < 0) j = int'(RING) - 1;
    tm1  = SW'(j);
    full = (tp1 == h);
    // rotate so that the head sits at cell zero
    for (int k = 0; k < int'(RING); k++) begin
      j = int'(h) + k;
      if (j >= int'(RING)) j = j - int'(RING);
      rot[k] = rd_row_q[j[SW-1:0]];
      j = k + int'(RING) - int'(h);
      if (j >= int'(RING)) j = j - int'(RING);
      wr_row[k] = work_q[j[SW-1:0]];
    end
    se      = {{SW{1'b0}}, cmd_q.slot};
    sidx    = se[SW-1:0];
    slot_ok = int'(cmd_q.slot) < int'(RING);
    j = int'(sidx) - int'(h);
    if (j < 0) j = j + int'(RING);
    off   = SW'(j);
    live  = slot_ok && (off < n);
    match = slot_ok && (rd_row_q[sidx] == cmd_q.task_id);
    rem   = rot[off];
    // close the gap behind the removed cell
    sh = rot;
    for (int k = 0; k < int'(RING) - 1; k++) begin
      if (k >= int'(off) && k + 1 < int'(n)) sh[k] = rot[k+1];
    end
    for (int k = 0; k < int'(RING); k++) begin
      if (k + 1 == int'(n)) sh[k] = '0;
    end
    pu    = rot;
    pu[n] = cmd_q.task_id;
    po    = rot;
    po[0] = '0;
  end

  assign cmd_ready_o    = (state_q == S_IDLE);
  assign res_valid_o    = res_valid_q;
  assign status_o       = res_st_q;
  assign out_task_o     = res_task_q;
  assign out_priority_o = res_prio_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) begin
      rd_row_q <= mem_q[cmd_i.queue[QW-1:0]];
    end
    if (state_q == S_WRITE) begin
      mem_q[qi] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      hn_q        <= '0;
      tn_q        <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      work_q      <= '0;
      wprio_q     <= '0;
      st_q        <= ST_OK;
      ot_q        <= '0;
      op_q        <= '0;
      res_valid_q <= 1'b0;
      res_st_q    <= ST_OK;
      res_task_q  <= '0;
      res_prio_q  <= '0;
      for (int i = 0; i < int'(NUM_QUEUES); i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      for (int i = 0; i < int'(NUM_TASKS); i++) begin
        prio_tab_q[i] <= '0;
      end
    end else begin
      if (res_ready_i && state_q != S_RESP) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          st_q    <= ST_OK;
          ot_q    <= '0;
          op_q    <= '0;
          hn_q    <= h;
          tn_q    <= t;
          n_q     <= n;
          cnt_q   <= '0;
          state_q <= S_RESP;
          unique case (cmd_q.cmd)
            CMD_PUSH: begin
              if (full) begin
                st_q <= ST_FULL;
              end else begin
                work_q                          <= pu;
                prio_tab_q[tidx(cmd_q.task_id)] <= cmd_q.prio;
                n_q                             <= n + SW'(1);
                tn_q                            <= tp1;
                state_q                         <= S_FETCH;
              end
            end
            CMD_POP: begin
              if (n == '0) begin
                st_q <= ST_EMPTY;
              end else begin
                ot_q    <= rot[0];
                op_q    <= prio_tab_q[tidx(rot[0])];
                work_q  <= po;
                hn_q    <= hp1;
                state_q <= S_WRITE;
              end
            end
            CMD_CHANGE: begin
              if (match) begin
                prio_tab_q[tidx(cmd_q.task_id)] <= cmd_q.prio;
                work_q                          <= rot;
                state_q                         <= S_FETCH;
              end else begin
                st_q <= ST_MISMATCH;
              end
            end
            CMD_REMOVE: begin
              if (n == '0) begin
                st_q <= ST_EMPTY;
              end else if (!live) begin
                st_q <= ST_MISMATCH;
              end else begin
                ot_q <= rem;
                op_q <= prio_tab_q[tidx(rem)];
                if (off == '0) begin
                  work_q  <= po;
                  hn_q    <= hp1;
                  state_q <= S_WRITE;
                end else begin
                  work_q  <= sh;
                  n_q     <= n - SW'(1);
                  tn_q    <= tm1;
                  state_q <= S_FETCH;
                end
              end
            end
            default: state_q <= S_RESP;
          endcase
        end
        S_FETCH: begin
          if (cnt_q == n_q) begin
            cnt_q   <= '0;
            state_q <= S_SORT;
          end else begin
            wprio_q[cnt_q] <= prio_tab_q[tidx(work_q[cnt_q])];
            cnt_q          <= cnt_q + SW'(1);
          end
        end
        S_SORT: begin
          if (cnt_q == n_q) begin
            state_q <= S_WRITE;
          end else begin
            // odd-even transposition pass, swap only on strictly lower priority
            for (int k = 0; k < int'(RING) - 1; k++) begin
              if ((k % 2) == int'(cnt_q[0]) && k + 1 < int'(n_q) &&
                  wprio_q[k] < wprio_q[k+1]) begin
                work_q[k]    <= work_q[k+1];
                work_q[k+1]  <= work_q[k];
                wprio_q[k]   <= wprio_q[k+1];
                wprio_q[k+1] <= wprio_q[k];
              end
            end
            cnt_q <= cnt_q + SW'(1);
          end
        end
        S_WRITE: begin
          head_q[qi] <= hn_q;
          tail_q[qi] <= tn_q;
          state_q    <= S_RESP;
        end
        S_RESP: begin
          if (!res_valid_q || res_ready_i) begin
            res_valid_q <= 1'b1;
            res_st_q    <= st_q;
            res_task_q  <= ot_q;
            res_prio_q  <= op_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/priority_sorted_wait_queue.sv @@
// ----------------------------------------------------------------------------
// priority_sorted_wait_queue
// Per-mutex wait queues kept highest priority first, with task priorities.
// ----------------------------------------------------------------------------
// One command is executed at a time; a two-entry queue lets new transactions
// in meanwhile, and the result register lets the next command start while a
// result waits. Pop and head removal pass through the load, write and response
// states, a refused command only through load and response. Push, priority
// change and removal behind the head first fetch one task priority per cycle
// from the priority table, then one pass of the odd-even compare-and-swap row
// per queued task re-sorts the queue.
// The queue store needs no clearing after reset.
module priority_sorted_wait_queue #(
  parameter int unsigned NUM_TASKS  = psq_pkg::DEF_NUM_TASKS,
  parameter int unsigned NUM_QUEUES = psq_pkg::DEF_NUM_QUEUES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [psq_pkg::CMD_W-1:0]     command_i,
  input  logic [psq_pkg::MUTEX_W-1:0]   mutex_index_i,
  input  logic [psq_pkg::TASK_W-1:0]    task_id_i,
  input  logic [psq_pkg::PRIO_W-1:0]    priority_req_i,
  input  logic [psq_pkg::SLOT_W-1:0]    slot_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [psq_pkg::STATUS_W-1:0]  status_o,
  output logic [psq_pkg::TASK_W-1:0]    out_task_o,
  output logic [psq_pkg::PRIO_W-1:0]    out_priority_o
);
  import psq_pkg::*;

  cmd_t fr_cmd, bk_cmd;
  logic fr_valid, fr_ready, bk_valid, bk_ready;

  psq_front #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .mutex_index_i  (mutex_index_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .slot_i         (slot_i),
    .cmd_valid_o    (fr_valid),
    .cmd_ready_i    (fr_ready),
    .cmd_o          (fr_cmd)
  );

  psq_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_cmd),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_cmd)
  );

  psq_back #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (bk_valid),
    .cmd_ready_o    (bk_ready),
    .cmd_i          (bk_cmd),
    .res_valid_o    (out_valid_o),
    .res_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_task_o     (out_task_o),
    .out_priority_o (out_priority_o)
  );

  // refused commands carry no task
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (out_task_o == '0) && (out_priority_o == '0))
    else $error("refused command returned a task");

  // the back is busy after taking a command
  a_back_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_valid && bk_ready |=> !bk_ready)
    else $error("back took a second command at once");

  // a new result only comes out of a busy back
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(bk_ready))
    else $error("result without a command in flight");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed wait-queue commands into the block. It predicts
// every status, task and priority from a behavioural copy of the queues, and
// checks the results in order while both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import psq_pkg::*;

  localparam int unsigned NT   = 16;
  localparam int unsigned NQ   = 4;
  localparam int unsigned RING = NT + 1;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    cmd_e               cmd;
    logic [MUTEX_W-1:0] mutex;
    logic [TASK_W-1:0]  tid;
    logic [PRIO_W-1:0]  prio;
    logic [SLOT_W-1:0]  slot;
  } wq_cmd_t;

  typedef struct packed {
    status_e            status;
    logic [TASK_W-1:0]  tid;
    logic [PRIO_W-1:0]  prio;
  } wq_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic [CMD_W-1:0]   cmd_d = '0;
  logic [MUTEX_W-1:0] mutex_d = '0;
  logic [TASK_W-1:0]  tid_d = '0;
  logic [PRIO_W-1:0]  prio_d = '0;
  logic [SLOT_W-1:0]  slot_d = '0;
  logic               in_ready, out_valid;
  logic [STATUS_W-1:0] status_q;
  logic [TASK_W-1:0]   otask_q;
  logic [PRIO_W-1:0]   oprio_q;

  priority_sorted_wait_queue u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(cmd_d), .mutex_index_i(mutex_d), .task_id_i(tid_d),
    .priority_req_i(prio_d), .slot_i(slot_d),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status_q), .out_task_o(otask_q), .out_priority_o(oprio_q)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow copy of the queues
  logic [TASK_W-1:0] wq_entry [NQ][RING];
  logic              wq_written [NQ][RING];
  logic [PRIO_W-1:0] task_prio [NT];
  int unsigned       wq_head [NQ];
  int unsigned       wq_tail [NQ];

  wq_cmd_t pending_cmds[$];
  wq_res_t expected_results[$];
  int unsigned sent_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 1'b0;

  function automatic int unsigned live_cnt(int unsigned q);
    return (wq_tail[q] + RING - wq_head[q]) % RING;
  endfunction

  function automatic void resort(int unsigned q);
    logic [TASK_W-1:0] buf_t [RING];
    logic [TASK_W-1:0] cur;
    int unsigned n, m;
    n = live_cnt(q);
    for (int k = 0; k < n; k++) buf_t[k] = wq_entry[q][(wq_head[q] + k) % RING];
    for (int k = 1; k < n; k++) begin
      cur = buf_t[k];
      m = k;
      while (m > 0 && task_prio[buf_t[m-1]] < task_prio[cur]) begin
        buf_t[m] = buf_t[m-1];
        m--;
      end
      buf_t[m] = cur;
    end
    for (int k = 0; k < n; k++) wq_entry[q][(wq_head[q] + k) % RING] = buf_t[k];
  endfunction

  function automatic void put_entry(int unsigned q, int unsigned s, logic [TASK_W-1:0] t);
    wq_entry[q][s] = t;
    wq_written[q][s] = 1'b1;
  endfunction

  function automatic wq_res_t predict_result(wq_cmd_t c);
    wq_res_t r;
    int unsigned q, h, n, s, off;
    r = '{ST_OK, '0, '0};
    q = c.mutex % NQ;
    h = wq_head[q];
    n = live_cnt(q);
    s = c.slot;
    case (c.cmd)
      CMD_PUSH: begin
        if ((wq_tail[q] + 1) % RING == h) begin
          r.status = ST_FULL;
        end else begin
          put_entry(q, wq_tail[q], c.tid);
          task_prio[c.tid] = c.prio;
          wq_tail[q] = (wq_tail[q] + 1) % RING;
          resort(q);
        end
      end
      CMD_POP: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.tid = wq_entry[q][h];
          r.prio = task_prio[r.tid];
          put_entry(q, h, '0);
          wq_head[q] = (h + 1) % RING;
        end
      end
      CMD_CHANGE: begin
        if (s < RING && wq_entry[q][s] == c.tid) begin
          task_prio[c.tid] = c.prio;
          resort(q);
        end else begin
          r.status = ST_MISMATCH;
        end
      end
      default: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (s >= RING || (s + RING - h) % RING >= n) begin
          r.status = ST_MISMATCH;
        end else begin
          off = (s + RING - h) % RING;
          r.tid = wq_entry[q][s];
          r.prio = task_prio[r.tid];
          if (off == 0) begin
            put_entry(q, h, '0);
            wq_head[q] = (h + 1) % RING;
          end else begin
            for (int k = off; k + 1 < n; k++)
              put_entry(q, (h + k) % RING, wq_entry[q][(h + k + 1) % RING]);
            wq_tail[q] = (wq_tail[q] + RING - 1) % RING;
            put_entry(q, wq_tail[q], '0);
            resort(q);
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic issue(cmd_e c, int unsigned q, int unsigned t, int unsigned p,
                       int unsigned s);
    wq_cmd_t it;
    it.cmd = c;
    it.mutex = MUTEX_W'(q);
    it.tid = TASK_W'(t);
    it.prio = PRIO_W'(p);
    it.slot = SLOT_W'(s);
    expected_results.push_back(predict_result(it));
    pending_cmds.push_back(it);
  endtask

  function automatic int unsigned live_slot(int unsigned q);
    return (wq_head[q] + $urandom_range(0, live_cnt(q) - 1)) % RING;
  endfunction

  function automatic int unsigned rand_prio();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      2: return $urandom_range(0, 3);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic random_cmd(int unsigned push_w);
    int unsigned q, s, sel;
    q = $urandom_range(0, 3);
    sel = $urandom_range(0, 99);
    if (sel < push_w) begin
      issue(CMD_PUSH, q, $urandom_range(0, 15), rand_prio(), $urandom_range(0, 31));
    end else if (sel < push_w + (100 - push_w) / 4) begin
      issue(CMD_POP, q, $urandom_range(0, 15), $urandom_range(0, 255),
            $urandom_range(0, 31));
    end else if (sel < push_w + (100 - push_w) * 5 / 8) begin
      if (live_cnt(q) > 0 && $urandom_range(0, 9) < 7) begin
        s = live_slot(q);
        issue(CMD_CHANGE, q, wq_entry[q][s], rand_prio(), s);
      end else begin
        s = $urandom_range(0, 31);
        if (s < RING && !wq_written[q][s]) s = 16 + $urandom_range(1, 15);
        issue(CMD_CHANGE, q, $urandom_range(0, 15), rand_prio(), s);
      end
    end else begin
      if (live_cnt(q) > 0 && $urandom_range(0, 9) < 7) s = live_slot(q);
      else s = $urandom_range(0, 31);
      issue(CMD_REMOVE, q, $urandom_range(0, 15), $urandom_range(0, 255), s);
    end
  endtask

  initial begin
    int unsigned push_w;
    for (int q = 0; q < NQ; q++) begin
      wq_head[q] = 0;
      wq_tail[q] = 0;
      for (int s = 0; s < RING; s++) begin
        wq_entry[q][s] = '0;
        wq_written[q][s] = 1'b0;
      end
    end
    for (int t = 0; t < NT; t++) task_prio[t] = '0;

    // directed part
    issue(CMD_POP, 1, 0, 0, 0);
    issue(CMD_REMOVE, 2, 15, 255, 0);
    for (int i = 0; i < NT; i++) issue(CMD_PUSH, 3, i, (i % 3 == 0) ? 255 : 0, 31);
    issue(CMD_PUSH, 3, 15, 128, 0);
    issue(CMD_CHANGE, 3, wq_entry[3][5], 200, 5);
    issue(CMD_CHANGE, 3, 4'hf, 17, 17);
    issue(CMD_REMOVE, 3, 0, 0, 31);
    issue(CMD_REMOVE, 3, 0, 0, 7);
    issue(CMD_REMOVE, 3, 0, 0, wq_head[3]);
    issue(CMD_POP, 3, 0, 0, 0);

    for (int i = 0; i < 1000; i++) begin
      if (i % 100 == 0) push_w = $urandom_range(20, 70);
      random_cmd(push_w);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  function automatic int unsigned phase_of();
    if (sent_cnt < 340) return 0;
    if (sent_cnt < 680) return 1;
    return 2;
  endfunction

  // driver
  always @(posedge clk) begin
    int unsigned idle_pct;
    wq_cmd_t it;
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) sent_cnt++;
        idle_pct = (phase_of() == 0) ? 21 : (phase_of() == 1) ? 61 : 0;
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          it = pending_cmds.pop_front();
          in_valid <= 1'b1;
          cmd_d <= it.cmd;
          mutex_d <= it.mutex;
          tid_d <= it.tid;
          prio_d <= it.prio;
          slot_d <= it.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    wq_res_t exp_r;
    int unsigned idle_pct;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result st=%0d task=%0d prio=%0d", $realtime,
                   status_q, otask_q, oprio_q);
        end else begin
          exp_r = expected_results.pop_front();
          if (status_q !== exp_r.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status,
                     status_q);
          end
          if (otask_q !== exp_r.tid) begin
            errors++;
            $display("%0t: task expected %0d actual %0d", $realtime, exp_r.tid, otask_q);
          end
          if (oprio_q !== exp_r.prio) begin
            errors++;
            $display("%0t: priority expected %0d actual %0d", $realtime, exp_r.prio,
                     oprio_q);
          end
        end
      end
      if (phase_of() == 2 && !hold_done) begin
        // long receiver stall so the block backs up
        hold_cnt++;
        if (hold_cnt >= 600) hold_done = 1'b1;
        out_ready <= 1'b0;
      end else begin
        idle_pct = (phase_of() == 0) ? 61 : (phase_of() == 1) ? 21 : 0;
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

@@ priority_sorted_wait_queue.f @@
rtl/core/psq_pkg.sv
rtl/core/psq_front.sv
rtl/core/psq_fifo.sv
rtl/core/psq_back.sv
rtl/core/priority_sorted_wait_queue.sv
verif/testbench.sv
